### hw/rtl/working_set_page_replacer_defines.svh
// Assertion macros for the page replacer RTL.
`ifndef WORKING_SET_PAGE_REPLACER_DEFINES_SVH
`define WORKING_SET_PAGE_REPLACER_DEFINES_SVH

// Concurrent check on a named clock, muted while the named reset is high.
`define WSPR_ASSERT_ON(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Same check on the block clock and reset.
`define WSPR_ASSERT(lbl, prop, msg) `WSPR_ASSERT_ON(lbl, clk, rst, prop, msg)

`endif

### hw/rtl/wspr_pkg.sv
// Package for the page replacer: codes, reset values, sequencer states, write controls.
package wspr_pkg;

  // Item kinds on req_type
  localparam logic [1:0] REQ_ACCESS = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_AGE       = 2'd0;
  localparam logic [1:0] CFG_FRAMES_IN_USE = 2'd1;

  // Register reset values
  localparam logic [15:0] MAX_AGE_RESET       = 16'd50;
  localparam logic [3:0]  FRAMES_IN_USE_RESET = 4'd5;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HIT,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Write strobes for the page table memories
  typedef struct packed {
    logic time_we;
    logic frame_we;
  } wr_t;

endpackage

### hw/rtl/wspr_table.sv
// Page table memories (frame and last-use time) with registered read and age check.
module wspr_table #(
  parameter int PAGES     = 16,
  parameter int FW        = 3,
  parameter int TIME_BITS = 32
) (
  input  logic                     clk,
  input  logic [$clog2(PAGES)-1:0] rd_addr,
  input  wspr_pkg::wr_t            wr,
  input  logic [$clog2(PAGES)-1:0] wr_addr,
  input  logic [FW-1:0]            wr_frame,
  input  logic [TIME_BITS-1:0]     now,
  input  logic [15:0]              max_age,
  output logic [FW-1:0]            rd_frame,
  output logic                     rd_stale
);

  localparam int AW = (TIME_BITS > 16) ? TIME_BITS : 16;

  logic [FW-1:0]        frame_mem [PAGES];
  logic [TIME_BITS-1:0] time_mem  [PAGES];
  logic [TIME_BITS-1:0] rd_time;
  logic [TIME_BITS-1:0] age;

  // Frame memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr.frame_we) begin
      frame_mem[wr_addr] <= wr_frame;
    end
    rd_frame <= frame_mem[rd_addr];
  end

  // Last-use memory: always written with the current time
  always_ff @(posedge clk) begin
    if (wr.time_we) begin
      time_mem[wr_addr] <= now;
    end
    rd_time <= time_mem[rd_addr];
  end

  // Age wraps with the time counter
  assign age      = now - rd_time;
  assign rd_stale = AW'(age) > AW'(max_age);

endmodule

### hw/rtl/working_set_page_replacer.sv
// Working-set page replacer top level: command port, config port, sequencer, state.
//
// Usage: an item (req_type, page) is taken at a rising edge with start high and
// busy low. Each item gives one result beat on hit/frame/evicted_valid/
// evicted_page/fault_total, marked by done for one cycle; the receiver cannot
// stall, so a beat must be taken when shown. Config writes (cfg_index 0 max_age,
// 1 frames_in_use) go on cfg_valid, with cfg_ready always high; the user must make
// them only while the block is idle, as the block itself does not enforce this.
// Timing: tick, clear, unknown items and faults that take a free frame give done
// the cycle after acceptance and leave busy low. A hit reads the frame memory in
// the HIT state, and done follows from there. A fault with all frames taken sweeps
// the page table through the memory read port one entry a cycle, up to the last
// entry or an old page that ends the sweep early; done follows through the FINISH
// state, and busy is high meanwhile.
// Reset: resident and referenced bits, time, fault and frame counters clear at
// once; max_age returns to 50 and frames_in_use to 5. Memories need no clearing
// pass: an entry is read only while its resident bit is set.
`include "working_set_page_replacer_defines.svh"

module working_set_page_replacer #(
  parameter int PAGES     = 16,
  parameter int FRAMES    = 8,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [3:0]  page,
  // result channel
  output logic        done,
  output logic        hit,
  output logic [2:0]  frame,
  output logic        evicted_valid,
  output logic [3:0]  evicted_page,
  output logic [15:0] fault_total,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int PW = $clog2(PAGES);
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int TW = $clog2(FRAMES + 1);
  localparam int CW = (TW > 4) ? TW : 4;
  localparam logic [PW-1:0] LAST_PAGE = PW'(PAGES - 1);

  // Page number wrapped into the table by repeated subtraction (at most 8 steps)
  function automatic logic [PW-1:0] page_wrap(input logic [3:0] pg);
    logic [8:0] v;
    v = 9'(pg);
    for (int k = 0; k < 8; k++) begin
      if (v >= 9'(PAGES)) begin
        v = v - 9'(PAGES);
      end
    end
    return PW'(v);
  endfunction

  wspr_pkg::state_t state, state_next;

  logic [15:0]          max_age;
  logic [3:0]           frames_in_use;
  logic [PAGES-1:0]     resident;
  logic [PAGES-1:0]     referenced;
  logic [TIME_BITS-1:0] now;
  logic [TW-1:0]        frames_taken;
  logic [15:0]          fault_count;

  logic [PW-1:0] req_page;
  logic [PW-1:0] scan_idx;
  logic          issue_on;
  logic          chk_valid;
  logic [PW-1:0] chk_idx;
  logic          vict_found;
  logic [PW-1:0] vict_idx;
  logic [FW-1:0] vict_frame;
  logic          first_found;
  logic [PW-1:0] first_idx;
  logic [FW-1:0] first_frame;

  logic [PW-1:0] in_page;
  logic          accept;
  logic          in_hit;
  logic [CW-1:0] limit;
  logic          free_frame;

  logic [PW-1:0] rd_addr;
  logic [PW-1:0] wr_addr;
  logic [FW-1:0] wr_frame;
  wspr_pkg::wr_t wr;
  logic [FW-1:0] rd_frame;
  logic          rd_stale;
  logic          done_next;

  logic          chk_res;
  logic          stale_hit;
  logic          scan_end;
  logic          ev_valid;
  logic [PW-1:0] ev_idx;
  logic [FW-1:0] ev_frame;
  logic          scan_last;

  // Input decode
  assign accept  = start && !busy;
  assign in_page = page_wrap(page);
  assign in_hit  = resident[in_page];

  // Frame limit: zero acts as one, clamp to the frame count
  always_comb begin
    if (frames_in_use == 4'd0) begin
      limit = CW'(1);
    end else if (CW'(frames_in_use) > CW'(FRAMES)) begin
      limit = CW'(FRAMES);
    end else begin
      limit = CW'(frames_in_use);
    end
  end
  assign free_frame = CW'(frames_taken) < limit;

  // Scan evaluation on the entry read last cycle
  assign chk_res   = chk_valid && resident[chk_idx];
  assign stale_hit = chk_res && !referenced[chk_idx] && rd_stale;
  assign scan_end  = stale_hit || (chk_valid && chk_idx == LAST_PAGE);

  // Victim choice at the end of a sweep: old page, else first resident one
  assign ev_valid = vict_found || first_found;
  assign ev_idx   = vict_found ? vict_idx : first_idx;
  always_comb begin
    if (vict_found) begin
      ev_frame = vict_frame;
    end else if (first_found) begin
      ev_frame = first_frame;
    end else begin
      ev_frame = '0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      wspr_pkg::ST_IDLE: begin
        if (accept && req_type == wspr_pkg::REQ_ACCESS) begin
          if (in_hit) begin
            state_next = wspr_pkg::ST_HIT;
          end else if (!free_frame) begin
            state_next = wspr_pkg::ST_SCAN;
          end
        end
      end
      wspr_pkg::ST_HIT:    state_next = wspr_pkg::ST_IDLE;
      wspr_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = wspr_pkg::ST_FINISH;
        end
      end
      wspr_pkg::ST_FINISH: state_next = wspr_pkg::ST_IDLE;
      default:             state_next = wspr_pkg::ST_IDLE;
    endcase
  end

  // Memory controls, busy and result strobe. A read that meets a write on one entry is
  // harmless: the sweep writes behind its read pointer, the hit writes the other memory.
  always_comb begin
    busy      = 1'b1;
    done_next = 1'b0;
    rd_addr   = in_page;
    wr_addr   = req_page;
    wr_frame  = ev_frame;
    wr        = '0;
    unique case (state)
      wspr_pkg::ST_IDLE: begin
        busy      = 1'b0;
        wr_addr   = in_page;
        wr_frame  = FW'(frames_taken);
        done_next = accept && (req_type != wspr_pkg::REQ_ACCESS || (!in_hit && free_frame));
        if (accept && req_type == wspr_pkg::REQ_ACCESS) begin
          wr.time_we  = in_hit || free_frame;
          wr.frame_we = !in_hit && free_frame;
        end
      end
      wspr_pkg::ST_HIT: begin
        done_next = 1'b1;
      end
      wspr_pkg::ST_SCAN: begin
        rd_addr    = scan_idx;
        wr_addr    = chk_idx;
        wr.time_we = chk_res && !stale_hit;
      end
      wspr_pkg::ST_FINISH: begin
        done_next   = 1'b1;
        wr.time_we  = 1'b1;
        wr.frame_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  wspr_table #(
    .PAGES     (PAGES),
    .FW        (FW),
    .TIME_BITS (TIME_BITS)
  ) u_table (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .wr_frame (wr_frame),
    .now      (now),
    .max_age  (max_age),
    .rd_frame (rd_frame),
    .rd_stale (rd_stale)
  );

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_age       <= wspr_pkg::MAX_AGE_RESET;
      frames_in_use <= wspr_pkg::FRAMES_IN_USE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == wspr_pkg::CFG_MAX_AGE) begin
        max_age <= cfg_data;
      end else if (cfg_index == wspr_pkg::CFG_FRAMES_IN_USE) begin
        frames_in_use <= cfg_data[3:0];
      end
    end
  end

  // Control state: sequencer, page bits, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= wspr_pkg::ST_IDLE;
      resident     <= '0;
      referenced   <= '0;
      now          <= '0;
      frames_taken <= '0;
      fault_count  <= '0;
      done         <= 1'b0;
      issue_on     <= 1'b0;
      chk_valid    <= 1'b0;
      vict_found   <= 1'b0;
      first_found  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      unique case (state)
        wspr_pkg::ST_IDLE: begin
          if (accept) begin
            unique case (req_type)
              wspr_pkg::REQ_ACCESS: begin
                if (in_hit) begin
                  referenced[in_page] <= 1'b1;
                end else begin
                  if (fault_count != 16'hFFFF) begin
                    fault_count <= fault_count + 16'd1;
                  end
                  if (free_frame) begin
                    resident[in_page]   <= 1'b1;
                    referenced[in_page] <= 1'b1;
                    frames_taken        <= frames_taken + TW'(1);
                  end else begin
                    issue_on    <= 1'b1;
                    chk_valid   <= 1'b0;
                    vict_found  <= 1'b0;
                    first_found <= 1'b0;
                  end
                end
              end
              wspr_pkg::REQ_TICK: begin
                now <= now + TIME_BITS'(1);
              end
              wspr_pkg::REQ_CLEAR: begin
                referenced <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        wspr_pkg::ST_HIT: begin
        end
        wspr_pkg::ST_SCAN: begin
          chk_valid <= issue_on;
          if (stale_hit || (issue_on && scan_idx == LAST_PAGE)) begin
            issue_on <= 1'b0;
          end
          if (stale_hit) begin
            vict_found <= 1'b1;
          end else if (chk_res && !first_found) begin
            first_found <= 1'b1;
          end
        end
        wspr_pkg::ST_FINISH: begin
          if (ev_valid) begin
            resident[ev_idx]   <= 1'b0;
            referenced[ev_idx] <= 1'b0;
          end
          resident[req_page]   <= 1'b1;
          referenced[req_page] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload: sweep pointers, victim records, result beat
  always_ff @(posedge clk) begin
    unique case (state)
      wspr_pkg::ST_IDLE: begin
        req_page      <= in_page;
        scan_idx      <= '0;
        hit           <= 1'b0;
        evicted_valid <= 1'b0;
        evicted_page  <= 4'd0;
        frame         <= (accept && req_type == wspr_pkg::REQ_ACCESS && !in_hit && free_frame)
                         ? 3'(frames_taken) : 3'd0;
      end
      wspr_pkg::ST_HIT: begin
        hit   <= 1'b1;
        frame <= 3'(rd_frame);
      end
      wspr_pkg::ST_SCAN: begin
        if (issue_on) begin
          chk_idx <= scan_idx;
          if (scan_idx != LAST_PAGE) begin
            scan_idx <= scan_idx + PW'(1);
          end
        end
        if (stale_hit) begin
          vict_idx   <= chk_idx;
          vict_frame <= rd_frame;
        end else if (chk_res && !first_found) begin
          first_idx   <= chk_idx;
          first_frame <= rd_frame;
        end
      end
      wspr_pkg::ST_FINISH: begin
        hit           <= 1'b0;
        frame         <= 3'(ev_frame);
        evicted_valid <= ev_valid;
        evicted_page  <= ev_valid ? 4'(ev_idx) : 4'd0;
      end
      default: begin
      end
    endcase
  end

  assign fault_total = fault_count;

  // Checks
  assign scan_last = state == wspr_pkg::ST_SCAN && chk_valid && chk_idx == LAST_PAGE;
  `WSPR_ASSERT(a_res_count, ($countones(resident) == int'(frames_taken)), "resident count off")
  `WSPR_ASSERT(a_frames_cap, (frames_taken <= TW'(FRAMES)), "frames taken over limit")
  `WSPR_ASSERT(a_scan_stop, (scan_last |=> state == wspr_pkg::ST_FINISH), "sweep ran past end")
  `WSPR_ASSERT(a_hit_beat, (state == wspr_pkg::ST_HIT |=> done && hit), "hit gave no beat")
  `WSPR_ASSERT(a_evict_miss, (done && evicted_valid |-> !hit), "eviction on a hit")

endmodule

### test/working_set_page_replacer_test.sv
// Self-checking testbench for the working-set page replacer: directed and randomised requests against a predictor.
module working_set_page_replacer_test;

  localparam int          PAGE_COUNT   = 16;
  localparam int          FRAME_COUNT  = 8;
  localparam logic [1:0]  REQ_UNKNOWN  = 2'd3;
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 150;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          CYCLE_LIMIT  = 250000;
  localparam int          REPORT_CAP   = 50;

  // One result beat as the block shows it
  typedef struct packed {
    logic        hit;
    logic [2:0]  frame;
    logic        evicted_valid;
    logic [3:0]  evicted_page;
    logic [15:0] fault_total;
  } access_outcome_t;

  // A request or a register write waiting to be driven
  typedef struct {
    bit          is_write;
    logic [1:0]  kind;
    logic [3:0]  pg;
    logic [1:0]  reg_index;
    logic [15:0] reg_data;
    int unsigned gap;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  req_type = wspr_pkg::REQ_ACCESS;
  logic [3:0]  page = 4'd0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = wspr_pkg::CFG_MAX_AGE;
  logic [15:0] cfg_data = 16'd0;
  logic        busy;
  logic        done;
  logic        hit;
  logic [2:0]  frame;
  logic        evicted_valid;
  logic [3:0]  evicted_page;
  logic [15:0] fault_total;
  logic        cfg_ready;

  // Predicted page table and counters
  logic [PAGE_COUNT-1:0] pg_resident = '0;
  logic [PAGE_COUNT-1:0] pg_referenced = '0;
  logic [2:0]            pg_frame [PAGE_COUNT];
  logic [31:0]           pg_last_use [PAGE_COUNT];
  logic [31:0]           now_time = '0;
  logic [3:0]            frames_taken = '0;
  logic [15:0]           fault_count = '0;
  logic [15:0]           max_age_reg = wspr_pkg::MAX_AGE_RESET;
  logic [3:0]            frame_limit_reg = wspr_pkg::FRAMES_IN_USE_RESET;

  request_t        request_q[$];
  access_outcome_t outcome_q[$];
  request_t        cur;
  bit              drv_active = 0;
  int unsigned     idle_left = 0;
  int unsigned     calm_left = 0;
  int unsigned     requests_taken = 0;
  int unsigned     outcomes_seen = 0;
  int unsigned     error_count = 0;
  int unsigned     cycle_count = 0;

  working_set_page_replacer i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .page          (page),
    .done          (done),
    .hit           (hit),
    .frame         (frame),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // Advance the predicted page table by one request and return its outcome
  function automatic access_outcome_t replace_page(input logic [1:0] kind, input logic [3:0] pg);
    access_outcome_t r;
    int              victim;
    int              lim;
    r = '0;
    if (kind == wspr_pkg::REQ_ACCESS) begin
      if (pg_resident[pg]) begin
        r.hit = 1'b1;
      end else begin
        if (fault_count != 16'hFFFF) fault_count = fault_count + 1'b1;
        lim = (frame_limit_reg == 0) ? 1 :
              (frame_limit_reg > FRAME_COUNT) ? FRAME_COUNT : int'(frame_limit_reg);
        if (frames_taken < lim) begin
          pg_frame[pg] = frames_taken[2:0];
          frames_taken = frames_taken + 1'b1;
        end else begin
          // sweep: refresh young or referenced pages up to the first stale one
          victim = PAGE_COUNT;
          for (int i = 0; i < PAGE_COUNT; i++) begin
            if (victim == PAGE_COUNT && pg_resident[i]) begin
              if (pg_referenced[i] || (now_time - pg_last_use[i]) <= {16'd0, max_age_reg})
                pg_last_use[i] = now_time;
              else
                victim = i;
            end
          end
          // nothing stale: fall back to the lowest resident page
          for (int i = 0; i < PAGE_COUNT; i++)
            if (victim == PAGE_COUNT && pg_resident[i]) victim = i;
          if (victim < PAGE_COUNT) begin
            r.evicted_valid = 1'b1;
            r.evicted_page  = victim[3:0];
            pg_resident[victim]   = 1'b0;
            pg_referenced[victim] = 1'b0;
            pg_frame[pg] = pg_frame[victim];
          end else begin
            pg_frame[pg] = 3'd0;
          end
        end
      end
      pg_resident[pg]   = 1'b1;
      pg_referenced[pg] = 1'b1;
      pg_last_use[pg]   = now_time;
      r.frame = pg_frame[pg];
    end else if (kind == wspr_pkg::REQ_TICK) begin
      now_time = now_time + 1;
    end else if (kind == wspr_pkg::REQ_CLEAR) begin
      pg_referenced = '0;
    end
    r.fault_total = fault_count;
    return r;
  endfunction

  // Idle gap for the next beat, with occasional back-to-back stretches
  function automatic int unsigned draw_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(5, 30);
    return $urandom_range(0, 8);
  endfunction

  task automatic push_request(input logic [1:0] kind, input logic [3:0] pg);
    request_t e;
    e = '{is_write: 0, kind: kind, pg: pg, reg_index: wspr_pkg::CFG_MAX_AGE, reg_data: '0,
          gap: draw_gap()};
    request_q.push_back(e);
  endtask

  task automatic push_write(input logic [1:0] idx, input logic [15:0] data);
    request_t e;
    e = '{is_write: 1, kind: wspr_pkg::REQ_ACCESS, pg: '0, reg_index: idx, reg_data: data,
          gap: draw_gap()};
    request_q.push_back(e);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Driver: presents requests and register writes, predicts on each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (start && !busy) begin
        outcome_q.push_back(replace_page(req_type, page));
        requests_taken++;
        drv_active = 0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == wspr_pkg::CFG_MAX_AGE) max_age_reg = cfg_data;
        else if (cfg_index == wspr_pkg::CFG_FRAMES_IN_USE) frame_limit_reg = cfg_data[3:0];
        drv_active = 0;
      end
      if (!drv_active && request_q.size() > 0) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (!request_q[0].is_write ||
                     (requests_taken == outcomes_seen && !busy)) begin
          // writes wait until every outstanding result is back
          cur = request_q.pop_front();
          idle_left = cur.gap;
          drv_active = 1;
        end
      end
      start     <= drv_active && !cur.is_write;
      cfg_valid <= drv_active && cur.is_write;
      req_type  <= cur.kind;
      page      <= cur.pg;
      cfg_index <= cur.reg_index;
      cfg_data  <= cur.reg_data;
    end
  end

  // Monitor: every done beat is matched against the oldest prediction
  always @(posedge clk) begin
    access_outcome_t want;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_CAP)
          $display("%0t: result with nothing expected, expected none, actual fault_total %0d",
                   $time, fault_total);
      end else begin
        want = outcome_q.pop_front();
        check_field("hit", 16'(want.hit), 16'(hit));
        check_field("frame", 16'(want.frame), 16'(frame));
        check_field("evicted_valid", 16'(want.evicted_valid), 16'(evicted_valid));
        check_field("evicted_page", 16'(want.evicted_page), 16'(evicted_page));
        check_field("fault_total", want.fault_total, fault_total);
      end
      outcomes_seen <= outcomes_seen + 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] age;
    logic [3:0]  frames;
    int unsigned hot_base;
    int unsigned sel;
    logic [3:0]  pg;
    for (int i = 0; i < PAGE_COUNT; i++) begin
      pg_frame[i]    = 3'd0;
      pg_last_use[i] = 32'd0;
    end

    // Directed: fill the frames, hit, tick, clear, unknown kind, fallback eviction
    push_request(wspr_pkg::REQ_ACCESS, 4'd0);
    push_request(wspr_pkg::REQ_ACCESS, 4'd15);
    push_request(wspr_pkg::REQ_ACCESS, 4'd0);
    push_request(wspr_pkg::REQ_TICK, 4'd15);
    push_request(wspr_pkg::REQ_CLEAR, 4'd0);
    push_request(REQ_UNKNOWN, 4'd9);
    push_request(wspr_pkg::REQ_ACCESS, 4'd1);
    push_request(wspr_pkg::REQ_ACCESS, 4'd2);
    push_request(wspr_pkg::REQ_ACCESS, 4'd3);
    push_request(wspr_pkg::REQ_ACCESS, 4'd4);
    push_request(wspr_pkg::REQ_CLEAR, 4'd0);
    push_request(wspr_pkg::REQ_ACCESS, 4'd5);
    // zero age, frame limit of zero (acts as one) and below frames taken
    push_write(wspr_pkg::CFG_MAX_AGE, 16'd0);
    push_write(wspr_pkg::CFG_FRAMES_IN_USE, 16'hFFF0);
    push_request(wspr_pkg::REQ_TICK, 4'd0);
    push_request(wspr_pkg::REQ_CLEAR, 4'd0);
    push_request(wspr_pkg::REQ_ACCESS, 4'd6);
    push_request(wspr_pkg::REQ_ACCESS, 4'd7);
    push_request(wspr_pkg::REQ_ACCESS, 4'd7);
    push_request(wspr_pkg::REQ_TICK, 4'd0);
    push_request(wspr_pkg::REQ_ACCESS, 4'd8);
    // widest age, frame limit above the frame count
    push_write(wspr_pkg::CFG_MAX_AGE, 16'hFFFF);
    push_write(wspr_pkg::CFG_FRAMES_IN_USE, 16'h000F);
    push_request(wspr_pkg::REQ_ACCESS, 4'd9);
    push_request(wspr_pkg::REQ_ACCESS, 4'd10);
    push_request(wspr_pkg::REQ_ACCESS, 4'd11);
    push_request(wspr_pkg::REQ_ACCESS, 4'd12);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: age = 16'd0;
        1: age = 16'hFFFF;
        2: age = 16'($urandom_range(0, 65535));
        default: age = 16'($urandom_range(1, 12));
      endcase
      case (ph)
        0: frames = 4'd1;
        1: frames = 4'd8;
        2: frames = 4'd0;
        3: frames = 4'd15;
        default: frames = 4'($urandom_range(1, 8));
      endcase
      push_write(wspr_pkg::CFG_MAX_AGE, age);
      push_write(wspr_pkg::CFG_FRAMES_IN_USE, (16'($urandom) & 16'hFFF0) | {12'd0, frames});
      hot_base = $urandom_range(0, PAGE_COUNT - 1);
      repeat (PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        // mostly a hot set of pages so that hits and evictions both happen
        if ($urandom_range(0, 9) < 7) pg = 4'((hot_base + $urandom_range(0, 5)) % PAGE_COUNT);
        else pg = 4'($urandom_range(0, PAGE_COUNT - 1));
        if (sel < 65) push_request(wspr_pkg::REQ_ACCESS, pg);
        else if (sel < 88) push_request(wspr_pkg::REQ_TICK, pg);
        else if (sel < 96) push_request(wspr_pkg::REQ_CLEAR, pg);
        else push_request(REQ_UNKNOWN, pg);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for all beats to be taken and all results back, then drain
    @(negedge clk);
    while (request_q.size() != 0 || drv_active || requests_taken != outcomes_seen)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (outcome_q.size() != 0) begin
      error_count++;
      $display("%0t: results missing, expected %0d more, actual 0", $time, outcome_q.size());
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
